// ===== hw/rtl/wps_pkg.sv =====
// wps_pkg: shared constants, register codes and types of the waveform page statistics unit
// no dependencies; imported by every module of the block

package wps_pkg;

    // default sizing
    localparam int PAGE_MAX_DEFAULT    = 512;
    localparam int SAMPLE_BITS_DEFAULT = 12;

    // configuration register layout
    localparam int CFG_INDEX_BITS   = 1;
    localparam int CFG_DATA_BITS    = 10;
    localparam int PAGE_LENGTH_BITS = 10;
    localparam int STEP_BITS        = 4;

    localparam int PAGE_LENGTH_MIN   = 2;
    localparam int PAGE_LENGTH_RESET = 299;
    localparam int STEP_MIN          = 1;
    localparam int STEP_MAX          = 8;
    localparam int STEP_RESET        = 5;

    // decimation phase runs 0 .. STEP_MAX-1
    localparam int PHASE_BITS = $clog2(STEP_MAX);

    // page records waiting between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PAGE_LENGTH     = 1'b0,
        CFG_DECIMATION_STEP = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV_SUM,
        B_DIV_SQ,
        B_ROOT,
        B_DONE
    } t_back_state;

    typedef struct packed {
        logic take_rec;
        logic load_out;
        logic step_last;
    } t_back_ctrl;

endpackage

// ===== hw/rtl/wps_front.sv =====
// wps_front: configuration registers, sample acceptance and per-page accumulation
// depends on wps_pkg; feeds finished page records into wps_queue

module wps_front
    import wps_pkg::*;
#(
    parameter int PAGE_MAX    = PAGE_MAX_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
    localparam int CW   = $clog2(PAGE_MAX + 1),
    localparam int SUMW = SAMPLE_BITS + CW,
    localparam int SQW  = 2 * SAMPLE_BITS + CW
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_push,
    input  logic [SAMPLE_BITS-1:0]    i_sample_code,
    output logic                      o_full,
    output logic                      o_q_push,
    input  logic                      i_q_full,
    output logic [SAMPLE_BITS-1:0]    o_rec_min,
    output logic [SAMPLE_BITS-1:0]    o_rec_max,
    output logic [SUMW-1:0]           o_rec_sum,
    output logic [SQW-1:0]            o_rec_sq,
    output logic [CW-1:0]             o_rec_count
);

    logic [PAGE_LENGTH_BITS-1:0] r_page_length;
    logic [STEP_BITS-1:0]        r_step;
    logic [CW-1:0]               r_index;
    logic [PHASE_BITS-1:0]       r_phase;
    logic [SAMPLE_BITS-1:0]      r_min;
    logic [SAMPLE_BITS-1:0]      r_max;
    logic [SUMW-1:0]             r_sum;
    logic [SQW-1:0]              r_sq;
    logic [CW-1:0]               r_count;

    logic [CW-1:0]              eff_len;
    logic [STEP_BITS-1:0]       eff_step;
    logic                       is_last;
    logic                       accept;
    logic                       take;
    logic [2*SAMPLE_BITS-1:0]   square;
    logic [SAMPLE_BITS-1:0]     n_min;
    logic [SAMPLE_BITS-1:0]     n_max;
    logic [SUMW-1:0]            n_sum;
    logic [SQW-1:0]             n_sq;
    logic [CW-1:0]              n_count;
    logic [PHASE_BITS-1:0]      n_phase;
    logic [PHASE_BITS:0]        phase_inc;

    // clamp the registers to their working range
    always_comb begin
        if (r_page_length < PAGE_LENGTH_BITS'(PAGE_LENGTH_MIN)) begin
            eff_len = CW'(PAGE_LENGTH_MIN);
        end else if (32'(r_page_length) > 32'(PAGE_MAX)) begin
            eff_len = CW'(PAGE_MAX);
        end else begin
            eff_len = CW'(r_page_length);
        end
        if (r_step < STEP_BITS'(STEP_MIN)) begin
            eff_step = STEP_BITS'(STEP_MIN);
        end else if (r_step > STEP_BITS'(STEP_MAX)) begin
            eff_step = STEP_BITS'(STEP_MAX);
        end else begin
            eff_step = r_step;
        end
    end

    assign is_last = ({1'b0, r_index} + (CW+1)'(1)) >= {1'b0, eff_len};
    // only the closing sample of a page needs room in the queue
    assign o_full  = is_last && i_q_full;
    assign accept  = i_push && !o_full;
    assign take    = (r_phase == '0);
    assign square  = (2*SAMPLE_BITS)'(i_sample_code) * (2*SAMPLE_BITS)'(i_sample_code);

    always_comb begin
        n_min     = (i_sample_code < r_min) ? i_sample_code : r_min;
        n_max     = (i_sample_code > r_max) ? i_sample_code : r_max;
        n_sum     = take ? r_sum + SUMW'(i_sample_code) : r_sum;
        n_sq      = take ? r_sq + SQW'(square) : r_sq;
        n_count   = take ? r_count + CW'(1) : r_count;
        phase_inc = {1'b0, r_phase} + (PHASE_BITS+1)'(1);
        n_phase   = (STEP_BITS'(phase_inc) >= eff_step) ? '0 : PHASE_BITS'(phase_inc);
    end

    assign o_q_push    = accept && is_last;
    assign o_rec_min   = n_min;
    assign o_rec_max   = n_max;
    assign o_rec_sum   = n_sum;
    assign o_rec_sq    = n_sq;
    assign o_rec_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_length <= PAGE_LENGTH_BITS'(PAGE_LENGTH_RESET);
            r_step        <= STEP_BITS'(STEP_RESET);
            r_index       <= '0;
            r_phase       <= '0;
            r_min         <= '1;
            r_max         <= '0;
            r_sum         <= '0;
            r_sq          <= '0;
            r_count       <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PAGE_LENGTH:     r_page_length <= PAGE_LENGTH_BITS'(i_cfg_data);
                CFG_DECIMATION_STEP: r_step        <= STEP_BITS'(i_cfg_data);
                default:             ;
            endcase
            // any write drops the page in progress
            r_index <= '0;
            r_phase <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
            r_count <= '0;
        end else if (accept) begin
            if (is_last) begin
                r_index <= '0;
                r_phase <= '0;
                r_min   <= '1;
                r_max   <= '0;
                r_sum   <= '0;
                r_sq    <= '0;
                r_count <= '0;
            end else begin
                r_index <= r_index + CW'(1);
                r_phase <= n_phase;
                r_min   <= n_min;
                r_max   <= n_max;
                r_sum   <= n_sum;
                r_sq    <= n_sq;
                r_count <= n_count;
            end
        end
    end

endmodule

// ===== hw/rtl/wps_queue.sv =====
// wps_queue: short first-in first-out store of finished page records
// depends on wps_pkg for its default depth

module wps_queue
    import wps_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/wps_back.sv =====
// wps_back: per-page divide and square root sequencer with the result register
// depends on wps_pkg; takes records from wps_queue

module wps_back
    import wps_pkg::*;
#(
    parameter int PAGE_MAX    = PAGE_MAX_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
    localparam int CW    = $clog2(PAGE_MAX + 1),
    localparam int SUMW  = SAMPLE_BITS + CW,
    localparam int SQW   = 2 * SAMPLE_BITS + CW,
    localparam int STP_W = $clog2(SQW)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    output logic                   o_q_pop,
    input  logic [SAMPLE_BITS-1:0] i_rec_min,
    input  logic [SAMPLE_BITS-1:0] i_rec_max,
    input  logic [SUMW-1:0]        i_rec_sum,
    input  logic [SQW-1:0]         i_rec_sq,
    input  logic [CW-1:0]          i_rec_count,
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic [SAMPLE_BITS-1:0] o_min_code,
    output logic [SAMPLE_BITS-1:0] o_max_code,
    output logic [SAMPLE_BITS-1:0] o_mean_code,
    output logic [SAMPLE_BITS-1:0] o_rms_code
);

    t_back_state r_state;
    t_back_state n_state;
    t_back_ctrl  ctrl;

    logic [STP_W-1:0]         r_step;
    logic [CW-1:0]            r_divisor;
    logic [CW-1:0]            r_rem;
    logic [SQW-1:0]           r_dvd;
    logic [SQW-1:0]           r_sq_hold;
    logic [SAMPLE_BITS-1:0]   r_min;
    logic [SAMPLE_BITS-1:0]   r_max;
    logic [SAMPLE_BITS-1:0]   r_mean;
    logic [2*SAMPLE_BITS-1:0] r_rad;
    logic [SAMPLE_BITS:0]     r_sqrem;
    logic [SAMPLE_BITS-1:0]   r_root;
    logic                     r_out_valid;
    logic [SAMPLE_BITS-1:0]   r_out_min;
    logic [SAMPLE_BITS-1:0]   r_out_max;
    logic [SAMPLE_BITS-1:0]   r_out_mean;
    logic [SAMPLE_BITS-1:0]   r_out_rms;

    // one restoring divide step
    logic [CW:0]              div_cand;
    logic                     div_ge;
    logic [CW:0]              div_diff;
    logic [CW-1:0]            n_rem;
    logic [SQW-1:0]           n_dvd;
    // one digit of the square root
    logic [SAMPLE_BITS+1:0]   rt_cand;
    logic [SAMPLE_BITS+1:0]   rt_trial;
    logic                     rt_ge;
    logic [SAMPLE_BITS+1:0]   rt_diff;
    logic [SAMPLE_BITS:0]     n_sqrem;
    logic [SAMPLE_BITS-1:0]   n_root;

    always_comb begin
        div_cand = {r_rem, r_dvd[SQW-1]};
        div_ge   = div_cand >= {1'b0, r_divisor};
        div_diff = div_cand - {1'b0, r_divisor};
        n_rem    = div_ge ? div_diff[CW-1:0] : div_cand[CW-1:0];
        n_dvd    = {r_dvd[SQW-2:0], div_ge};
    end

    always_comb begin
        rt_cand  = {r_sqrem[SAMPLE_BITS-1:0], r_rad[2*SAMPLE_BITS-1 -: 2]};
        rt_trial = {r_root, 2'b01};
        rt_ge    = rt_cand >= rt_trial;
        rt_diff  = rt_cand - rt_trial;
        n_sqrem  = rt_ge ? rt_diff[SAMPLE_BITS:0] : rt_cand[SAMPLE_BITS:0];
        n_root   = {r_root[SAMPLE_BITS-2:0], rt_ge};
    end

    // control outputs
    always_comb begin
        ctrl = '0;
        unique case (r_state)
            B_IDLE:    ctrl.take_rec  = !i_q_empty;
            B_DIV_SUM: ctrl.step_last = (r_step == STP_W'(SUMW - 1));
            B_DIV_SQ:  ctrl.step_last = (r_step == STP_W'(SQW - 1));
            B_ROOT:    ctrl.step_last = (r_step == STP_W'(SAMPLE_BITS - 1));
            B_DONE:    ctrl.load_out  = !r_out_valid || i_pop;
            default:   ctrl = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:    if (ctrl.take_rec)  n_state = B_DIV_SUM;
            B_DIV_SUM: if (ctrl.step_last) n_state = B_DIV_SQ;
            B_DIV_SQ:  if (ctrl.step_last) n_state = B_ROOT;
            B_ROOT:    if (ctrl.step_last) n_state = B_DONE;
            B_DONE:    if (ctrl.load_out)  n_state = B_IDLE;
            default:   n_state = B_IDLE;
        endcase
    end

    assign o_q_pop = ctrl.take_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctrl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_min     <= i_rec_min;
                r_max     <= i_rec_max;
                r_divisor <= i_rec_count;
                r_sq_hold <= i_rec_sq;
                r_dvd     <= {i_rec_sum, {(SQW-SUMW){1'b0}}};
                r_rem     <= '0;
                r_step    <= '0;
            end
            B_DIV_SUM: begin
                if (ctrl.step_last) begin
                    r_mean <= n_dvd[SAMPLE_BITS-1:0];
                    r_dvd  <= r_sq_hold;
                    r_rem  <= '0;
                    r_step <= '0;
                end else begin
                    r_dvd  <= n_dvd;
                    r_rem  <= n_rem;
                    r_step <= r_step + STP_W'(1);
                end
            end
            B_DIV_SQ: begin
                if (ctrl.step_last) begin
                    r_rad   <= n_dvd[2*SAMPLE_BITS-1:0];
                    r_sqrem <= '0;
                    r_root  <= '0;
                    r_step  <= '0;
                end else begin
                    r_dvd  <= n_dvd;
                    r_rem  <= n_rem;
                    r_step <= r_step + STP_W'(1);
                end
            end
            B_ROOT: begin
                r_rad   <= {r_rad[2*SAMPLE_BITS-3:0], 2'b00};
                r_sqrem <= n_sqrem;
                r_root  <= n_root;
                r_step  <= r_step + STP_W'(1);
            end
            B_DONE: begin
                if (ctrl.load_out) begin
                    r_out_min  <= r_min;
                    r_out_max  <= r_max;
                    r_out_mean <= r_mean;
                    r_out_rms  <= r_root;
                end
            end
            default: ;
        endcase
    end

    assign o_empty     = !r_out_valid;
    assign o_min_code  = r_out_min;
    assign o_max_code  = r_out_max;
    assign o_mean_code = r_out_mean;
    assign o_rms_code  = r_out_rms;

endmodule

// ===== hw/rtl/waveform_page_statistics_unit.sv =====
// waveform_page_statistics_unit: top level of the per-page min/max/mean/rms block
// depends on wps_pkg, wps_front, wps_queue and wps_back
//
// usage
//   samples come in through a queue-style port: a transfer happens on a clock edge with
//   push high and full low, one sample per cycle at most
//   results leave through a queue-style port: the oldest result sits on o_*_code while
//   empty is low and is transferred on an edge with pop high and empty low
//   one result per page: min and max over every sample, floor mean and floor root of the
//   floor mean square over the first sample and every decimation_step-th one after it
//   page_length (index 0) and decimation_step (index 1) are written through i_cfg_*;
//   each write throws away the page in progress, write only while the block is idle
// timing
//   the front takes one sample every cycle while full is low; the closing sample of a page
//   pushes a record into a two-deep queue
//   the back takes each record through its states idle, sum divide, square-sum divide,
//   root and done, using a shared bit-serial divider and a root unit, and loads the result
//   register once the previous result has been popped; it takes no new record until then
//   full rises only on a page's closing sample while two records wait, i.e. when pages
//   come faster than the back finishes them or results are not popped
// reset
//   synchronous, active low: registers return to 299 and 5, the page and queue are cleared
//   and the result register is emptied; while pop stays low the result holds and the back waits

module waveform_page_statistics_unit
    import wps_pkg::*;
#(
    parameter int PAGE_MAX    = PAGE_MAX_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic [SAMPLE_BITS-1:0]    i_sample_code,
    output logic                      empty,
    input  logic                      pop,
    output logic [SAMPLE_BITS-1:0]    o_min_code,
    output logic [SAMPLE_BITS-1:0]    o_max_code,
    output logic [SAMPLE_BITS-1:0]    o_mean_code,
    output logic [SAMPLE_BITS-1:0]    o_rms_code
);

    localparam int CW    = $clog2(PAGE_MAX + 1);
    localparam int SUMW  = SAMPLE_BITS + CW;
    localparam int SQW   = 2 * SAMPLE_BITS + CW;
    localparam int REC_W = 2 * SAMPLE_BITS + SUMW + SQW + CW;

    // record handed from front to back
    logic                   q_push;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_empty;
    logic [REC_W-1:0]       q_wr_data;
    logic [REC_W-1:0]       q_rd_data;
    logic [SAMPLE_BITS-1:0] fr_min;
    logic [SAMPLE_BITS-1:0] fr_max;
    logic [SUMW-1:0]        fr_sum;
    logic [SQW-1:0]         fr_sq;
    logic [CW-1:0]          fr_count;
    logic [SAMPLE_BITS-1:0] bk_min;
    logic [SAMPLE_BITS-1:0] bk_max;
    logic [SUMW-1:0]        bk_sum;
    logic [SQW-1:0]         bk_sq;
    logic [CW-1:0]          bk_count;

    wps_front #(
        .PAGE_MAX    (PAGE_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_sample_code (i_sample_code),
        .o_full        (full),
        .o_q_push      (q_push),
        .i_q_full      (q_full),
        .o_rec_min     (fr_min),
        .o_rec_max     (fr_max),
        .o_rec_sum     (fr_sum),
        .o_rec_sq      (fr_sq),
        .o_rec_count   (fr_count)
    );

    // pack the record: min, max, sum, square sum, count
    assign q_wr_data = {fr_min, fr_max, fr_sum, fr_sq, fr_count};

    wps_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty)
    );

    assign {bk_min, bk_max, bk_sum, bk_sq, bk_count} = q_rd_data;

    wps_back #(
        .PAGE_MAX    (PAGE_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_rec_min   (bk_min),
        .i_rec_max   (bk_max),
        .i_rec_sum   (bk_sum),
        .i_rec_sq    (bk_sq),
        .i_rec_count (bk_count),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_min_code  (o_min_code),
        .o_max_code  (o_max_code),
        .o_mean_code (o_mean_code),
        .o_rms_code  (o_rms_code)
    );

endmodule

// ===== hw/rtl/wps_checker.sv =====
// wps_checker: port-level assertions on the waveform page statistics unit
// depends on wps_pkg; bound to waveform_page_statistics_unit at the end of this file

module wps_checker
    import wps_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   full,
    input logic                   empty,
    input logic                   pop,
    input logic [SAMPLE_BITS-1:0] o_min_code,
    input logic [SAMPLE_BITS-1:0] o_max_code,
    input logic [SAMPLE_BITS-1:0] o_mean_code,
    input logic [SAMPLE_BITS-1:0] o_rms_code
);

    // reset leaves no result and room for samples
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("result or stall flag left over after reset");

    // a waiting result holds until transferred
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_min_code) && $stable(o_max_code)
                           && $stable(o_mean_code) && $stable(o_rms_code))
        else $error("waiting result changed without a transfer");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_min_code <= o_max_code)
        else $error("page minimum above maximum");

    // the decimated mean stays inside the page range and the rms at or below the maximum
    a_stats_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_mean_code >= o_min_code && o_mean_code <= o_max_code
                   && o_rms_code <= o_max_code)
        else $error("mean or rms outside the page range");

endmodule

bind waveform_page_statistics_unit wps_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_wps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_min_code  (o_min_code),
    .o_max_code  (o_max_code),
    .o_mean_code (o_mean_code),
    .o_rms_code  (o_rms_code)
);
